FILE: hw/rtl/variance_stddev_unit_top_macros.svh
// assertion macros for the variance unit
`ifndef VARIANCE_STDDEV_UNIT_TOP_MACROS_SVH
`define VARIANCE_STDDEV_UNIT_TOP_MACROS_SVH

// same-cycle implication, checked outside reset
`define VSU_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define VSU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/vsu_pkg.sv
// ----------------------------------------------------------------------------
// vsu_pkg
// Shared types and constants of the variance / standard deviation unit.
// ----------------------------------------------------------------------------
package vsu_pkg;

  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned FRAC_W     = 16;
  localparam int unsigned VALUE_W    = 48;
  localparam int unsigned ROOT_IN_W  = 64;
  localparam int unsigned ROOT_W     = 32;
  localparam int unsigned DDOF_W     = 4;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 4;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_STD_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DDOF     = 2'd1;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last;
  } in_req_t;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               error;
    logic               overflow;
  } out_res_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic check;
    logic mean_go;
    logic mu_load;
    logic pass_go;
    logic var_go;
    logic var_load;
    logic root_go;
    logic root_load;
    logic emit;
  } vsu_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic too_few;
    logic div_done;
    logic pass_done;
    logic root_done;
    logic std_mode;
  } vsu_sts_t;

endpackage

FILE: hw/rtl/vsu_div.sv
// ----------------------------------------------------------------------------
// vsu_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module vsu_div #(
  parameter int unsigned DVW = 59,
  parameter int unsigned DSW = 11
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic [DVW-1:0] dividend,
  input  logic [DSW-1:0] divisor,
  output logic           done,
  output logic [DVW-1:0] quotient
);

  localparam int unsigned CNTW = $clog2(DVW + 1);

  logic [DVW-1:0]  q_r;
  logic [DSW-1:0]  rem_r;
  logic [DSW-1:0]  dsr_r;
  logic [CNTW-1:0] cnt_r;
  logic            run_r;
  logic            done_r;
  logic [DSW:0]    rem_sh;
  logic            ge;
  logic [DSW-1:0]  rem_nxt;

  // one trial subtraction
  always_comb begin
    rem_sh  = {rem_r, q_r[DVW-1]};
    ge      = rem_sh >= {1'b0, dsr_r};
    rem_nxt = ge ? DSW'(rem_sh - {1'b0, dsr_r}) : rem_sh[DSW-1:0];
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= CNTW'(DVW);
      end else if (run_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNTW'(1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // operands
  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      rem_r <= '0;
      dsr_r <= divisor;
    end else if (run_r) begin
      q_r   <= {q_r[DVW-2:0], ge};
      rem_r <= rem_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule

FILE: hw/rtl/vsu_sqrt.sv
// ----------------------------------------------------------------------------
// vsu_sqrt
// Digit-by-digit integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module vsu_sqrt (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [vsu_pkg::ROOT_IN_W-1:0] radicand,
  output logic                          done,
  output logic [vsu_pkg::ROOT_W-1:0]    root
);

  localparam int unsigned RW   = vsu_pkg::ROOT_W;
  localparam int unsigned IW   = vsu_pkg::ROOT_IN_W;
  localparam int unsigned CNTW = $clog2(RW + 1);

  logic [IW-1:0]   op_r;
  logic [RW+1:0]   rem_r;
  logic [RW-1:0]   root_r;
  logic [CNTW-1:0] cnt_r;
  logic            run_r;
  logic            done_r;
  logic [RW+1:0]   rem_sh;
  logic [RW+1:0]   trial;
  logic            ge;

  // bring down two bits and try
  always_comb begin
    rem_sh = {rem_r[RW-1:0], op_r[IW-1:IW-2]};
    trial  = {root_r, 2'b01};
    ge     = rem_sh >= trial;
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= CNTW'(RW);
      end else if (run_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNTW'(1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // operands
  always_ff @(posedge clk) begin
    if (start) begin
      op_r   <= radicand;
      rem_r  <= '0;
      root_r <= '0;
    end else if (run_r) begin
      op_r   <= {op_r[IW-3:0], 2'b00};
      rem_r  <= ge ? (rem_sh - trial) : rem_sh;
      root_r <= {root_r[RW-2:0], ge};
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule

FILE: hw/rtl/vsu_dp.sv
// ----------------------------------------------------------------------------
// vsu_dp
// Datapath: sample memory, running sum, squared-deviation pass, shared
// divider, square root and result register.
// ----------------------------------------------------------------------------
module vsu_dp #(
  parameter int unsigned MAX_SAMPLES = 1024
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  vsu_pkg::vsu_cmd_t              cmd,
  output vsu_pkg::vsu_sts_t              sts,
  input  vsu_pkg::in_req_t               in_req,
  input  logic                           cfg_valid,
  input  logic [vsu_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [vsu_pkg::CFG_DATA_W-1:0] cfg_data,
  output logic                           out_valid,
  output vsu_pkg::out_res_t              out_res
);

  localparam int unsigned SW   = vsu_pkg::SAMPLE_W;
  localparam int unsigned FW   = vsu_pkg::FRAC_W;
  localparam int unsigned VW   = vsu_pkg::VALUE_W;
  localparam int unsigned AW   = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
  localparam int unsigned CW   = $clog2(MAX_SAMPLES + 1);
  localparam int unsigned SUMW = SW + CW;
  localparam int unsigned ACCW = 2 * (SW + FW) + CW;
  localparam int unsigned DVW  = ACCW - FW;
  localparam int unsigned PADW = DVW - SUMW - FW;
  localparam int unsigned MUW  = SW + FW + 1;
  localparam int unsigned DW   = SW + FW + 2;
  localparam int unsigned MAGW = SW + FW;
  localparam int unsigned DDW  = vsu_pkg::DDOF_W;

  logic signed [SW-1:0]   mem [MAX_SAMPLES];
  logic [CW-1:0]          count_r;
  logic signed [SUMW-1:0] sum_r;
  logic                   dropped_r;
  logic                   std_mode_r;
  logic [DDW-1:0]         ddof_r;

  logic signed [MUW-1:0]  mu_r;
  logic [CW-1:0]          idx_r;
  logic                   pass_r;
  logic                   v1_r, v2_r, v3_r;
  logic signed [SW-1:0]   rd_r;
  logic [MAGW-1:0]        mag_r;
  logic [2*MAGW-1:0]      sq_r;
  logic [ACCW-1:0]        acc_r;
  logic [VW-1:0]          val_r;
  logic                   err_r;
  logic                   out_valid_r;
  vsu_pkg::out_res_t      out_res_r;

  logic [SUMW-1:0]        sum_mag;
  logic [DVW-1:0]         div_dvd;
  logic [CW-1:0]          div_dsr;
  logic                   div_done;
  logic [DVW-1:0]         div_q;
  logic                   root_done;
  logic [vsu_pkg::ROOT_W-1:0] root_q;
  logic                   issue;
  logic signed [DW-1:0]   dev;
  logic [DW-1:0]          dev_abs;
  logic                   var_sat;
  logic [VW-1:0]          var_val;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      std_mode_r <= 1'b0;
      ddof_r     <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        vsu_pkg::CFG_STD_MODE: std_mode_r <= cfg_data[0];
        vsu_pkg::CFG_DDOF:     ddof_r     <= cfg_data[DDW-1:0];
        default: ;
      endcase
    end
  end

  // set state: count, running sum, dropped flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= '0;
      sum_r     <= '0;
      dropped_r <= 1'b0;
    end else if (cmd.emit) begin
      count_r   <= '0;
      sum_r     <= '0;
      dropped_r <= 1'b0;
    end else if (cmd.load) begin
      if (count_r < CW'(MAX_SAMPLES)) begin
        count_r <= count_r + 1'b1;
        sum_r   <= sum_r + SUMW'(in_req.sample);
      end else begin
        dropped_r <= 1'b1;
      end
    end
  end

  // sample memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (cmd.load && (count_r < CW'(MAX_SAMPLES))) begin
      mem[count_r[AW-1:0]] <= in_req.sample;
    end
    rd_r <= mem[idx_r[AW-1:0]];
  end

  // shared divider: mean first, then the variance
  always_comb begin
    sum_mag = sum_r[SUMW-1] ? SUMW'(-sum_r) : SUMW'(sum_r);
    if (cmd.mean_go) begin
      div_dvd = {{PADW{1'b0}}, sum_mag, {FW{1'b0}}};
      div_dsr = count_r;
    end else begin
      div_dvd = acc_r[ACCW-1:FW];
      div_dsr = count_r - CW'(ddof_r);
    end
  end

  vsu_div #(.DVW(DVW), .DSW(CW)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.mean_go | cmd.var_go),
    .dividend (div_dvd),
    .divisor  (div_dsr),
    .done     (div_done),
    .quotient (div_q)
  );

  // mean, truncated toward zero
  always_ff @(posedge clk) begin
    if (cmd.mu_load) begin
      mu_r <= sum_r[SUMW-1] ? -MUW'(div_q[MUW-1:0]) : MUW'(div_q[MUW-1:0]);
    end
  end

  // deviation pass control
  assign issue = pass_r && (idx_r < count_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pass_r <= 1'b0;
      idx_r  <= '0;
      v1_r   <= 1'b0;
      v2_r   <= 1'b0;
      v3_r   <= 1'b0;
    end else begin
      v1_r <= issue;
      v2_r <= v1_r;
      v3_r <= v2_r;
      if (cmd.pass_go) begin
        pass_r <= 1'b1;
        idx_r  <= '0;
      end else begin
        if (cmd.var_go) begin
          pass_r <= 1'b0;
        end
        if (issue) begin
          idx_r <= idx_r + 1'b1;
        end
      end
    end
  end

  // deviation, magnitude, square, accumulate
  always_comb begin
    dev     = (DW'(rd_r) <<< FW) - DW'(mu_r);
    dev_abs = dev[DW-1] ? DW'(-dev) : DW'(dev);
  end

  always_ff @(posedge clk) begin
    if (v1_r) begin
      mag_r <= dev_abs[MAGW-1:0];
    end
    if (v2_r) begin
      sq_r <= mag_r * mag_r;
    end
    if (cmd.pass_go) begin
      acc_r <= '0;
    end else if (v3_r) begin
      acc_r <= acc_r + ACCW'(sq_r);
    end
  end

  // variance saturation and square root
  always_comb begin
    var_sat = |div_q[DVW-1:VW];
    var_val = var_sat ? {VW{1'b1}} : div_q[VW-1:0];
  end

  vsu_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.root_go),
    .radicand ({val_r, {FW{1'b0}}}),
    .done     (root_done),
    .root     (root_q)
  );

  // result value and error
  always_ff @(posedge clk) begin
    if (cmd.check) begin
      val_r <= '0;
      err_r <= ({{DDW{1'b0}}, count_r} <= {{CW{1'b0}}, ddof_r});
    end else if (cmd.var_load) begin
      val_r <= var_val;
    end else if (cmd.root_load) begin
      val_r <= VW'(root_q);
    end
  end

  // result register, shown for one cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_res_r.value    <= val_r;
      out_res_r.error    <= err_r;
      out_res_r.overflow <= dropped_r;
    end
  end

  // status to controller
  always_comb begin
    sts.too_few   = ({{DDW{1'b0}}, count_r} <= {{CW{1'b0}}, ddof_r});
    sts.div_done  = div_done;
    sts.pass_done = pass_r && (idx_r == count_r) && !v1_r && !v2_r && !v3_r;
    sts.root_done = root_done;
    sts.std_mode  = std_mode_r;
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

endmodule

FILE: hw/rtl/vsu_ctrl.sv
// ----------------------------------------------------------------------------
// vsu_ctrl
// Controller: takes samples, then sequences mean, deviation pass,
// division, optional square root and result.
// ----------------------------------------------------------------------------
module vsu_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              last,
  output logic              busy,
  output vsu_pkg::vsu_cmd_t cmd,
  input  vsu_pkg::vsu_sts_t sts
);

  typedef enum logic [10:0] {
    ST_IDLE      = 11'b000_0000_0001,
    ST_CHECK     = 11'b000_0000_0010,
    ST_MEAN_GO   = 11'b000_0000_0100,
    ST_MEAN_WAIT = 11'b000_0000_1000,
    ST_PASS_GO   = 11'b000_0001_0000,
    ST_PASS_WAIT = 11'b000_0010_0000,
    ST_VAR_GO    = 11'b000_0100_0000,
    ST_VAR_WAIT  = 11'b000_1000_0000,
    ST_ROOT_GO   = 11'b001_0000_0000,
    ST_ROOT_WAIT = 11'b010_0000_0000,
    ST_EMIT      = 11'b100_0000_0000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        cmd.load = start;
        if (start && last) begin
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        cmd.check = 1'b1;
        state_nxt = sts.too_few ? ST_EMIT : ST_MEAN_GO;
      end
      ST_MEAN_GO: begin
        cmd.mean_go = 1'b1;
        state_nxt   = ST_MEAN_WAIT;
      end
      ST_MEAN_WAIT: begin
        if (sts.div_done) begin
          cmd.mu_load = 1'b1;
          state_nxt   = ST_PASS_GO;
        end
      end
      ST_PASS_GO: begin
        cmd.pass_go = 1'b1;
        state_nxt   = ST_PASS_WAIT;
      end
      ST_PASS_WAIT: begin
        if (sts.pass_done) begin
          state_nxt = ST_VAR_GO;
        end
      end
      ST_VAR_GO: begin
        cmd.var_go = 1'b1;
        state_nxt  = ST_VAR_WAIT;
      end
      ST_VAR_WAIT: begin
        if (sts.div_done) begin
          cmd.var_load = 1'b1;
          state_nxt    = sts.std_mode ? ST_ROOT_GO : ST_EMIT;
        end
      end
      ST_ROOT_GO: begin
        cmd.root_go = 1'b1;
        state_nxt   = ST_ROOT_WAIT;
      end
      ST_ROOT_WAIT: begin
        if (sts.root_done) begin
          cmd.root_load = 1'b1;
          state_nxt     = ST_EMIT;
        end
      end
      ST_EMIT: begin
        cmd.emit  = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != ST_IDLE);

endmodule

FILE: hw/rtl/variance_stddev_unit_top.sv
// ----------------------------------------------------------------------------
// variance_stddev_unit_top
// Variance or standard deviation of a set of signed 16-bit samples.
// ----------------------------------------------------------------------------
// Samples are taken one per cycle while busy is low, up to MAX_SAMPLES per
// set (more are dropped and flagged). After the sample marked last, busy
// stays high while the set is worked on: a check step (with too few samples
// for ddof it goes straight to an error result), the mean through the shared
// one-bit-per-cycle divider, the deviation pass over the sample memory at
// one read per cycle, the final division and, in std mode, the square root.
// The result is shown for exactly one cycle on out_valid and cannot be held
// off by the receiver; it appears as busy drops, so the next set may start
// in that same cycle. Configuration may only be written while busy is low.
module variance_stddev_unit_top #(
  parameter int unsigned MAX_SAMPLES = 1024
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  vsu_pkg::in_req_t               in_req,
  output logic                           out_valid,
  output vsu_pkg::out_res_t              out_res,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [vsu_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [vsu_pkg::CFG_DATA_W-1:0] cfg_data
);

`include "variance_stddev_unit_top_macros.svh"

  vsu_pkg::vsu_cmd_t cmd;
  vsu_pkg::vsu_sts_t sts;

  assign cfg_ready = 1'b1;

  // sequencer
  vsu_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .last  (in_req.last),
    .busy  (busy),
    .cmd   (cmd),
    .sts   (sts)
  );

  // arithmetic and storage
  vsu_dp #(.MAX_SAMPLES(MAX_SAMPLES)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_req    (in_req),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

  // checks
  `VSU_ASSERT_NOW(a_res_idle, out_valid, !busy, "result while busy")
  `VSU_ASSERT_NEXT(a_last_busy, start && !busy && in_req.last, busy, "last not taken up")
  `VSU_ASSERT_NEXT(a_one_res, out_valid, !out_valid, "results back to back")
  `VSU_ASSERT_NOW(a_err_zero, out_valid && out_res.error, out_res.value == '0, "error value")

endmodule
